>>> src/assert_macros.svh
// assertion macros shared by the dequantizing dot product rtl
// no dependencies; the assertion bodies drop out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_AT(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

>>> src/ddp_pkg.sv
// widths, mode codes and the queued word type of the dequantizing dot product
// no dependencies
package ddp_pkg;

	localparam int ACT_W   = 16;
	localparam int BYTE_W  = 8;
	localparam int NIB_W   = 4;
	localparam int CODE_W  = 8;
	localparam int MIN_W   = 16;
	localparam int SCALE_W = 16;
	localparam int BIAS_W  = 16;
	localparam int CS_W    = CODE_W + SCALE_W;
	localparam int W_W     = CS_W + 2;
	localparam int PROD_W  = ACT_W + W_W;
	localparam int ACC_W   = 48;
	localparam int BIAS_SH = 8;

	localparam int QUEUE_DEPTH_DEF = 4;

	typedef enum logic {
		MODE_NIBBLE = 1'b0,
		MODE_BYTE   = 1'b1
	} code_mode_t;

	typedef struct packed {
		logic signed [ACT_W-1:0]   act;
		logic        [CODE_W-1:0]  code;
		logic signed [MIN_W-1:0]   gmin;
		logic        [SCALE_W-1:0] gscale;
		logic signed [BIAS_W-1:0]  bias;
		logic                      first;
		logic                      last;
	} ddp_item_t;

endpackage

>>> src/ddp_in_if.sv
// input word channel: valid/ready handshake with the item payload
// uses ddp_pkg for field widths
interface ddp_in_if;
	logic                               valid;
	logic                               ready;
	logic signed [ddp_pkg::ACT_W-1:0]   activation;
	logic        [ddp_pkg::BYTE_W-1:0]  weight_byte;
	logic                               high_nibble;
	logic signed [ddp_pkg::MIN_W-1:0]   group_min;
	logic        [ddp_pkg::SCALE_W-1:0] group_scale;
	logic signed [ddp_pkg::BIAS_W-1:0]  bias_value;
	logic                               first_item;
	logic                               last_item;

	modport source (output valid, activation, weight_byte, high_nibble, group_min,
		group_scale, bias_value, first_item, last_item, input ready);
	modport sink (input valid, activation, weight_byte, high_nibble, group_min,
		group_scale, bias_value, first_item, last_item, output ready);
endinterface

>>> src/ddp_out_if.sv
// result word channel: valid/ready handshake with the dot product result
// uses ddp_pkg for field widths
interface ddp_out_if;
	logic                             valid;
	logic                             ready;
	logic signed [ddp_pkg::ACC_W-1:0] dot_sum;
	logic                             saturated;

	modport source (output valid, dot_sum, saturated, input ready);
	modport sink (input valid, dot_sum, saturated, output ready);
endinterface

>>> src/ddp_front.sv
// front end: accepts input words, holds the code width mode, extracts the code
// uses ddp_pkg and ddp_in_if
module ddp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic                cfg_wr_data,
	ddp_in_if.sink              ingress,
	input  logic                full,
	output logic                push,
	output ddp_pkg::ddp_item_t  push_item
);

	ddp_pkg::code_mode_t        mode_q;
	logic [ddp_pkg::CODE_W-1:0] code;
	logic [ddp_pkg::NIB_W-1:0]  nib;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ddp_pkg::MODE_NIBBLE;
		end else if (cfg_wr_en) begin
			mode_q <= ddp_pkg::code_mode_t'(cfg_wr_data);
		end
	end

	assign nib = ingress.high_nibble ? ingress.weight_byte[2*ddp_pkg::NIB_W-1:ddp_pkg::NIB_W]
	                                 : ingress.weight_byte[ddp_pkg::NIB_W-1:0];

	always_comb begin
		case (mode_q)
			ddp_pkg::MODE_BYTE:   code = ingress.weight_byte;
			ddp_pkg::MODE_NIBBLE: code = {{(ddp_pkg::CODE_W-ddp_pkg::NIB_W){1'b0}}, nib};
			default:              code = ingress.weight_byte;
		endcase
	end

	assign ingress.ready = !full;
	assign push          = ingress.valid && !full;

	always_comb begin
		push_item.act    = ingress.activation;
		push_item.code   = code;
		push_item.gmin   = ingress.group_min;
		push_item.gscale = ingress.group_scale;
		push_item.bias   = ingress.bias_value;
		push_item.first  = ingress.first_item;
		push_item.last   = ingress.last_item;
	end

endmodule

>>> src/ddp_queue.sv
// short fifo of classified words between front and back end
// uses ddp_pkg and assert_macros.svh
`include "assert_macros.svh"
module ddp_queue #(
	parameter int DEPTH = ddp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  ddp_pkg::ddp_item_t push_item,
	input  logic               pop,
	output ddp_pkg::ddp_item_t head_item,
	output logic               full,
	output logic               empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	ddp_pkg::ddp_item_t slots_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		ptr_next = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);
	assign head_item = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	`ASSERT_NEVER(a_no_pop_empty, clk, arst_n, pop && empty, "queue popped while empty")
	`ASSERT_NEVER(a_no_push_full, clk, arst_n, push && full, "queue pushed while full")

endmodule

>>> src/ddp_back.sv
// back end: dequantize, multiply, saturating accumulate, result register
// uses ddp_pkg, ddp_out_if and assert_macros.svh
`include "assert_macros.svh"
module ddp_back (
	input  logic               clk,
	input  logic               arst_n,
	input  ddp_pkg::ddp_item_t head_item,
	input  logic               empty,
	output logic               pop,
	ddp_out_if.source          egress
);

	localparam int ACC_W  = ddp_pkg::ACC_W;
	localparam int PROD_W = ddp_pkg::PROD_W;
	localparam int W_W    = ddp_pkg::W_W;
	localparam int CS_W   = ddp_pkg::CS_W;
	localparam int BIAS_W = ddp_pkg::BIAS_W;

	logic adv;

	// stage 1: queued word
	logic               valid_s1;
	ddp_pkg::ddp_item_t item_s1;

	// stage 2: dequantized weight
	logic                               valid_s2;
	logic signed [W_W-1:0]              w_s2;
	logic signed [ddp_pkg::ACT_W-1:0]   act_s2;
	logic signed [BIAS_W-1:0]           bias_s2;
	logic                               first_s2;
	logic                               last_s2;

	// stage 3: product
	logic                     valid_s3;
	logic signed [PROD_W-1:0] prod_s3;
	logic signed [BIAS_W-1:0] bias_s3;
	logic                     first_s3;
	logic                     last_s3;

	logic signed [ACC_W-1:0] acc_q;
	logic                    clip_q;
	logic                    out_valid_q;
	logic signed [ACC_W-1:0] out_sum_q;
	logic                    out_sat_q;

	logic [CS_W-1:0]          cs;
	logic signed [W_W-1:0]    w_d;
	logic signed [PROD_W-1:0] prod_d;
	logic [ACC_W-1:0]         base;
	logic [ACC_W:0]           sum_wide;
	logic                     ovf_hi;
	logic                     ovf_lo;
	logic signed [ACC_W-1:0]  sum_sat;
	logic                     clip_d;

	assign adv = !out_valid_q || egress.ready;
	assign pop = adv && !empty;

	assign cs  = {{(CS_W-ddp_pkg::CODE_W){1'b0}}, item_s1.code}
	           * {{(CS_W-ddp_pkg::SCALE_W){1'b0}}, item_s1.gscale};
	assign w_d = {{(W_W-ddp_pkg::MIN_W){item_s1.gmin[ddp_pkg::MIN_W-1]}}, item_s1.gmin}
	           + {{(W_W-CS_W){1'b0}}, cs};

	assign prod_d = act_s2 * w_s2;

	assign base     = first_s3
	                ? {{(ACC_W-BIAS_W-ddp_pkg::BIAS_SH){bias_s3[BIAS_W-1]}}, bias_s3,
	                   {ddp_pkg::BIAS_SH{1'b0}}}
	                : acc_q;
	assign sum_wide = {base[ACC_W-1], base} + {{(ACC_W+1-PROD_W){prod_s3[PROD_W-1]}}, prod_s3};
	assign ovf_hi   = (sum_wide[ACC_W:ACC_W-1] == 2'b01);
	assign ovf_lo   = (sum_wide[ACC_W:ACC_W-1] == 2'b10);

	always_comb begin
		if (ovf_hi) begin
			sum_sat = {1'b0, {(ACC_W-1){1'b1}}};
		end else if (ovf_lo) begin
			sum_sat = {1'b1, {(ACC_W-1){1'b0}}};
		end else begin
			sum_sat = sum_wide[ACC_W-1:0];
		end
	end

	assign clip_d = (!first_s3 && clip_q) || ovf_hi || ovf_lo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			acc_q       <= '0;
			clip_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= !empty;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3 && last_s3;
			if (valid_s3) begin
				acc_q  <= sum_sat;
				clip_q <= clip_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1  <= head_item;
			w_s2     <= w_d;
			act_s2   <= item_s1.act;
			bias_s2  <= item_s1.bias;
			first_s2 <= item_s1.first;
			last_s2  <= item_s1.last;
			prod_s3  <= prod_d;
			bias_s3  <= bias_s2;
			first_s3 <= first_s2;
			last_s3  <= last_s2;
			out_sum_q <= sum_sat;
			out_sat_q <= clip_d;
		end
	end

	assign egress.valid     = out_valid_q;
	assign egress.dot_sum   = out_sum_q;
	assign egress.saturated = out_sat_q;

	`ASSERT_AT(a_out_is_acc, clk, arst_n, out_valid_q |-> (out_sum_q == acc_q), "result word differs from accumulator")
	`ASSERT_AT(a_out_flag_is_clip, clk, arst_n, out_valid_q |-> (out_sat_q == clip_q), "result flag differs from clip state")
	`ASSERT_AT(a_clip_sticky, clk, arst_n, (adv && valid_s3 && !first_s3 && clip_q) |=> clip_q, "clip flag dropped inside a dot product")

endmodule

>>> src/dequantizing_dot_product_unit.sv
// top level of the group quantized int4/int8 dequantizing dot product unit
// uses ddp_pkg, ddp_in_if, ddp_out_if, ddp_front, ddp_queue, ddp_back
//
// channel   dir  word
// ingress   in   activation, weight_byte, high_nibble, group_min, group_scale,
//                bias_value, first_item, last_item
// egress    out  dot_sum, saturated (one word per last_item)
// cfg       in   cfg_wr_en / cfg_wr_data -> code_width_mode
//
// sustained rate one word per cycle unless egress holds a result word; the
// accumulate loop is a single 48-bit add and saturate
// from ingress accept to egress valid: queue, queued word register, weight
// multiply, activation multiply, accumulate into the result register
// reset clears the mode, queue pointers, accumulator, clip flag and valids
// a result word held on egress freezes the back end; the queue absorbs
// QUEUE_DEPTH words before ingress ready drops
module dequantizing_dot_product_unit #(
	parameter int QUEUE_DEPTH = ddp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_wr_en,
	input  logic      cfg_wr_data,
	ddp_in_if.sink    ingress,
	ddp_out_if.source egress
);

	logic               push;
	logic               pop;
	logic               full;
	logic               empty;
	ddp_pkg::ddp_item_t push_item;
	ddp_pkg::ddp_item_t head_item;

	ddp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.ingress     (ingress),
		.full        (full),
		.push        (push),
		.push_item   (push_item)
	);

	ddp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head_item (head_item),
		.full      (full),
		.empty     (empty)
	);

	ddp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_item (head_item),
		.empty     (empty),
		.pop       (pop),
		.egress    (egress)
	);

endmodule
